### design/pof_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pof_pkg: shared types and constants for the percussive onset fraction block
// Field widths, register indexes, reset values and the classified-bin record
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package pof_pkg;

    localparam int MAG_IN_W    = 24;  // magnitude port width
    localparam int BINS_W      = 12;
    localparam int THR_W       = 16;
    localparam int ZT_W        = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int FRAC_W      = 17;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_OUT_W   = 12;
    localparam int RISE_SHIFT  = 14;  // Q2.14 threshold
    localparam int POS_STATE_W = 11;  // bin position wraps at this width
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;

    localparam logic [BINS_W-1:0] BINS_RESET = 12'd1024;
    localparam logic [THR_W-1:0]  RISE_RESET = 16'd23143;
    localparam logic [ZT_W-1:0]   ZERO_RESET = 24'd0;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic [BINS_W-1:0] bins_in_use;
        logic [THR_W-1:0]  rise_threshold;
        logic [ZT_W-1:0]   zero_threshold;
    } cfg_t;

    typedef struct packed {
        logic rising;
        logic nonzero;
        logic last;
    } bin_class_t;

endpackage

### design/pof_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pof_ram: generic simple dual-port RAM
// One write port, one read port, registered read. A read and a write to the
// same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module pof_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/pof_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pof_queue: small FIFO of classified bins
// Decouples the classify pipeline from the counting and divide back end.
// ----------------------------------------------------------------------------
module pof_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  pof_pkg::bin_class_t        push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output pof_pkg::bin_class_t        head,
    output logic [pof_pkg::QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(pof_pkg::QUEUE_DEPTH);

    pof_pkg::bin_class_t          slots_reg [pof_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]             rd_ptr_reg;
    logic [PTR_W-1:0]             rd_ptr_next;
    logic [PTR_W-1:0]             wr_ptr_reg;
    logic [PTR_W-1:0]             wr_ptr_next;
    logic [pof_pkg::QCNT_W-1:0]   count_reg;
    logic [pof_pkg::QCNT_W-1:0]   count_next;

    always_comb
    begin
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + pof_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - pof_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];
    assign count      = count_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < pof_pkg::QUEUE_DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");
`endif

endmodule

### design/pof_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pof_front: bin intake and classification
// Tracks the bin position, swaps each magnitude with the previous frame's
// value in the store, then runs the ratio test in two stages and pushes a
// rising / nonzero / last-bin record into the queue.
// ----------------------------------------------------------------------------
module pof_front #(
    parameter int MAX_BINS = 2048,
    parameter int MAG_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pof_pkg::cfg_t               cfg,
    input  logic [pof_pkg::MAG_IN_W-1:0] magnitude,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pof_pkg::QCNT_W-1:0]  queue_count,
    output logic                        push,
    output pof_pkg::bin_class_t         push_entry
);

    localparam int POS_W    = $clog2(MAX_BINS);
    localparam int TOT_W    = $clog2(MAX_BINS + 1);
    localparam int CMP_W    = (MAG_BITS > pof_pkg::ZT_W) ? MAG_BITS : pof_pkg::ZT_W;
    localparam int PROD_W   = MAG_BITS + pof_pkg::THR_W;
    localparam int POS_WRAP = (1 << pof_pkg::POS_STATE_W) - 1;

    logic                accept;
    logic [TOT_W-1:0]    total;
    logic [POS_W:0]      slot_plus;
    logic                last;
    logic [MAG_BITS-1:0] now;
    logic                old_valid;

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [TOT_W-1:0]    hw_reg;      // entries below this mark have been written
    logic [TOT_W-1:0]    hw_next;

    logic [MAG_BITS-1:0] ram_rdata;

    logic                s1_valid_reg;
    logic [MAG_BITS-1:0] s1_now_reg;
    logic                s1_last_reg;
    logic                s1_old_valid_reg;
    logic [MAG_BITS-1:0] s1_old;
    logic                s1_old_gt;
    logic                s1_now_gt;
    logic [PROD_W-1:0]   s1_prod;

    logic                s2_valid_reg;
    logic [MAG_BITS-1:0] s2_now_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic                s2_old_gt_reg;
    logic                s2_now_gt_reg;
    logic                s2_last_reg;
    logic [PROD_W-1:0]   s2_scaled;
    logic                s2_rising;

    // ---- stage 0: position and store access ----
    always_comb
    begin
        if (cfg.bins_in_use == '0)
        begin
            total = TOT_W'(1);
        end
        else if (32'(cfg.bins_in_use) > MAX_BINS)
        begin
            total = TOT_W'(MAX_BINS);
        end
        else
        begin
            total = TOT_W'(cfg.bins_in_use);
        end
    end

    assign accept    = in_valid && in_ready;
    assign slot_plus = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign last      = (32'(slot_plus) >= 32'(total));
    assign now       = MAG_BITS'(magnitude);
    assign old_valid = (32'(pos_reg) < 32'(hw_reg));

    always_comb
    begin
        pos_next = pos_reg;
        hw_next  = hw_reg;
        if (accept)
        begin
            pos_next = last ? '0 : POS_W'(32'(slot_plus) & POS_WRAP);
            if (32'(pos_reg) == 32'(hw_reg))
            begin
                hw_next = hw_reg + TOT_W'(1);
            end
        end
    end

    pof_ram #(
        .WIDTH (MAG_BITS),
        .DEPTH (MAX_BINS)
    ) u_prev_store (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_reg),
        .wdata (now),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // ---- stage 1: old value, threshold compares, multiply ----
    always_comb
    begin
        s1_old    = s1_old_valid_reg ? ram_rdata : '0;
        s1_old_gt = CMP_W'(s1_old) > CMP_W'(cfg.zero_threshold);
        s1_now_gt = CMP_W'(s1_now_reg) > CMP_W'(cfg.zero_threshold);
        s1_prod   = PROD_W'(cfg.rise_threshold) * PROD_W'(s1_old);
    end

    // ---- stage 2: ratio compare ----
    always_comb
    begin
        s2_scaled = PROD_W'({s2_now_reg, {pof_pkg::RISE_SHIFT{1'b0}}});
        s2_rising = s2_old_gt_reg ? (s2_scaled >= s2_prod_reg) : s2_now_gt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            hw_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            hw_reg       <= hw_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_now_reg       <= now;
        s1_last_reg      <= last;
        s1_old_valid_reg <= old_valid;
        s2_now_reg       <= s1_now_reg;
        s2_prod_reg      <= s1_prod;
        s2_old_gt_reg    <= s1_old_gt;
        s2_now_gt_reg    <= s1_now_gt;
        s2_last_reg      <= s1_last_reg;
    end

    // room for everything already in flight plus this transaction
    assign in_ready = (32'(queue_count) + 32'(s1_valid_reg) + 32'(s2_valid_reg))
                      < pof_pkg::QUEUE_DEPTH;

    assign push               = s2_valid_reg;
    assign push_entry.rising  = s2_rising;
    assign push_entry.nonzero = s2_now_gt_reg;
    assign push_entry.last    = s2_last_reg;

`ifndef ASSERT_OFF
    a_fill_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(hw_reg) <= MAX_BINS) && (32'(pos_reg) <= 32'(hw_reg)))
        else $error("bin position beyond written prefix");
`endif

endmodule

### design/pof_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pof_back: frame counters, fraction divider and result register
// Counts rising and nonzero bins, hands each finished frame to a restoring
// divider (one quotient bit per cycle) and holds the result for the sink.
// Counting of the next frame runs while the divider works.
// ----------------------------------------------------------------------------
module pof_back #(
    parameter int MAX_BINS = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  pof_pkg::bin_class_t           head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pof_pkg::FRAC_W-1:0]    rise_fraction,
    output logic [pof_pkg::CNT_OUT_W-1:0] rising_bins,
    output logic [pof_pkg::CNT_OUT_W-1:0] nonzero_bins
);

    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int QB     = pof_pkg::FRAC_BITS;
    localparam int STEP_W = $clog2(QB);

    logic [CNT_W-1:0]  rise_cnt_reg;
    logic [CNT_W-1:0]  nz_cnt_reg;
    logic [CNT_W-1:0]  rise_sum;
    logic [CNT_W-1:0]  nz_sum;
    logic              div_free;
    logic              start;
    logic              deliver;

    logic              div_active_reg;
    logic              div_hold_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    rem_reg;
    logic [QB-1:0]     quo_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W-1:0]  res_rise_reg;
    logic [CNT_W-1:0]  res_nz_reg;
    logic              res_zero_reg;
    logic              res_sat_reg;

    logic [CNT_W:0]    rem_sh;
    logic              rem_ge;
    logic [CNT_W:0]    rem_step;

    logic                       out_valid_reg;
    logic [pof_pkg::FRAC_W-1:0] out_frac_reg;
    logic [CNT_W-1:0]           out_rise_reg;
    logic [CNT_W-1:0]           out_nz_reg;
    logic [pof_pkg::FRAC_W-1:0] frac_value;

    assign div_free = !div_active_reg && !div_hold_reg;
    assign pop      = head_valid && (!head.last || div_free);
    assign start    = pop && head.last;
    assign rise_sum = rise_cnt_reg + CNT_W'(head.rising);
    assign nz_sum   = nz_cnt_reg + CNT_W'(head.nonzero);
    assign deliver  = div_hold_reg && (!out_valid_reg || out_ready);

    // remainder stays below the divisor, so doubling fits in CNT_W+1 bits
    always_comb
    begin
        rem_sh   = {rem_reg[CNT_W-1:0], 1'b0};
        rem_ge   = rem_sh >= {1'b0, den_reg};
        rem_step = rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    always_comb
    begin
        if (res_zero_reg)
        begin
            frac_value = '0;
        end
        else if (res_sat_reg)
        begin
            frac_value = pof_pkg::FRAC_ONE;
        end
        else
        begin
            frac_value = {1'b0, quo_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_cnt_reg   <= '0;
            nz_cnt_reg     <= '0;
            div_active_reg <= 1'b0;
            div_hold_reg   <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rise_cnt_reg <= head.last ? '0 : rise_sum;
                nz_cnt_reg   <= head.last ? '0 : nz_sum;
            end

            if (start)
            begin
                div_active_reg <= 1'b1;
                step_reg       <= '0;
            end
            else if (div_active_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (32'(step_reg) == QB - 1)
                begin
                    div_active_reg <= 1'b0;
                    div_hold_reg   <= 1'b1;
                end
            end
            else if (deliver)
            begin
                div_hold_reg <= 1'b0;
            end

            if (deliver)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= {1'b0, rise_sum};
            quo_reg      <= '0;
            den_reg      <= nz_sum;
            res_rise_reg <= rise_sum;
            res_nz_reg   <= nz_sum;
            res_zero_reg <= (nz_sum == '0);
            res_sat_reg  <= (rise_sum >= nz_sum);
        end
        else if (div_active_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[QB-2:0], rem_ge};
        end

        if (deliver)
        begin
            out_frac_reg <= frac_value;
            out_rise_reg <= res_rise_reg;
            out_nz_reg   <= res_nz_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rise_fraction = out_frac_reg;
    assign rising_bins   = pof_pkg::CNT_OUT_W'(out_rise_reg);
    assign nonzero_bins  = pof_pkg::CNT_OUT_W'(out_nz_reg);

`ifndef ASSERT_OFF
    a_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_active_reg && div_hold_reg))
        else $error("divider both running and holding");

    a_full_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_nz_reg != '0) && (out_rise_reg == out_nz_reg))
        |-> (out_frac_reg == pof_pkg::FRAC_ONE))
        else $error("all bins rising but fraction below one");

    a_zero_fraction: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_nz_reg == '0) || (out_rise_reg == '0)))
        |-> (out_frac_reg == '0))
        else $error("fraction nonzero with empty count");
`endif

endmodule

### design/percussive_onset_fraction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percussive_onset_fraction_top: percussive onset detection function
// Streams spectral magnitudes, compares each bin with the previous frame,
// and emits the fraction of rising bins among nonzero bins once per frame.
//
//   channel   signals                                 direction
//   input     in_valid/in_ready, magnitude            sink
//   output    out_valid/out_ready, rise_fraction,     source
//             rising_bins, nonzero_bins
//   config    cfg_we, cfg_index, cfg_data             write only
//
// One bin per cycle enters while in_ready is high; the store swap and ratio test
// take three stages. The divider retires one quotient bit per cycle, so a frame's
// last bin waits in the queue until the divider is free; with short frames the
// queue fills and the input then stalls.
// The previous-frame store needs no clearing pass: a fill mark makes
// unwritten entries read as zero. Reset restores the register defaults.
// ----------------------------------------------------------------------------
module percussive_onset_fraction_top #(
    parameter int MAX_BINS = 2048,
    parameter int MAG_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pof_pkg::MAG_IN_W-1:0]   magnitude,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pof_pkg::FRAC_W-1:0]     rise_fraction,
    output logic [pof_pkg::CNT_OUT_W-1:0]  rising_bins,
    output logic [pof_pkg::CNT_OUT_W-1:0]  nonzero_bins,
    input  logic                           cfg_we,
    input  logic [pof_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pof_pkg::CFG_W-1:0]      cfg_data
);

    pof_pkg::cfg_t               cfg_reg;
    logic                        push;
    pof_pkg::bin_class_t         push_entry;
    logic                        pop;
    logic                        head_valid;
    pof_pkg::bin_class_t         head;
    logic [pof_pkg::QCNT_W-1:0]  queue_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bins_in_use    <= pof_pkg::BINS_RESET;
            cfg_reg.rise_threshold <= pof_pkg::RISE_RESET;
            cfg_reg.zero_threshold <= pof_pkg::ZERO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pof_pkg::REG_BINS_IN_USE:
                begin
                    cfg_reg.bins_in_use <= cfg_data[pof_pkg::BINS_W-1:0];
                end
                pof_pkg::REG_RISE_THRESHOLD:
                begin
                    cfg_reg.rise_threshold <= cfg_data[pof_pkg::THR_W-1:0];
                end
                pof_pkg::REG_ZERO_THRESHOLD:
                begin
                    cfg_reg.zero_threshold <= cfg_data[pof_pkg::ZT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    pof_front #(
        .MAX_BINS (MAX_BINS),
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .magnitude   (magnitude),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .queue_count (queue_count),
        .push        (push),
        .push_entry  (push_entry)
    );

    pof_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (queue_count)
    );

    pof_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rise_fraction (rise_fraction),
        .rising_bins   (rising_bins),
        .nonzero_bins  (nonzero_bins)
    );

endmodule

### tb/percussive_onset_fraction_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percussive_onset_fraction_top_test: self-checking bench for the onset block
// Streams spectral magnitude frames through percussive_onset_fraction_top
// with random gaps and output back-pressure. A cycle-free model of the
// previous-frame store and rise/nonzero counters predicts each frame result,
// and the monitor compares every result transaction field by field.
// ----------------------------------------------------------------------------
module percussive_onset_fraction_top_test;

    localparam int CFG_IDX_W  = pof_pkg::CFG_IDX_W;
    localparam int CFG_W      = pof_pkg::CFG_W;
    localparam int MAG_IN_W   = pof_pkg::MAG_IN_W;
    localparam int FRAC_W     = pof_pkg::FRAC_W;
    localparam int FRAC_BITS  = pof_pkg::FRAC_BITS;
    localparam int CNT_OUT_W  = pof_pkg::CNT_OUT_W;
    localparam int BINS_W     = pof_pkg::BINS_W;
    localparam int THR_W      = pof_pkg::THR_W;
    localparam int ZT_W       = pof_pkg::ZT_W;
    localparam int RISE_SHIFT = pof_pkg::RISE_SHIFT;

    localparam int                   STORE_BINS   = 2048;
    localparam int                   RANDOM_ITEMS = 800;
    localparam int                   SETTLE_CYC   = 48;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [MAG_IN_W-1:0]  MAG_MAX      = 24'hFFFFFF;

    typedef struct {
        logic [FRAC_W-1:0]    fraction;
        logic [CNT_OUT_W-1:0] rising;
        logic [CNT_OUT_W-1:0] nonzero;
    } frame_result_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [MAG_IN_W-1:0]  magnitude = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FRAC_W-1:0]    rise_fraction;
    logic [CNT_OUT_W-1:0] rising_bins;
    logic [CNT_OUT_W-1:0] nonzero_bins;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    percussive_onset_fraction_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .magnitude     (magnitude),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rise_fraction (rise_fraction),
        .rising_bins   (rising_bins),
        .nonzero_bins  (nonzero_bins),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // stimulus side
    logic [MAG_IN_W-1:0] bins_to_send[$];
    logic [MAG_IN_W-1:0] stim_prev[STORE_BINS];
    int unsigned         stim_pos = 0;
    logic [BINS_W-1:0]   stim_bins = pof_pkg::BINS_RESET;
    logic [THR_W-1:0]    stim_rise = pof_pkg::RISE_RESET;
    logic [ZT_W-1:0]     stim_zero = pof_pkg::ZERO_RESET;
    int unsigned         sent_count = 0;
    int unsigned         accepted_count = 0;
    bit                  calm = 1'b0;
    int                  in_gap = 0;
    int                  out_stall = 0;

    // onset model state
    logic [MAG_IN_W-1:0] onset_prev[STORE_BINS];
    int unsigned         onset_pos = 0;
    int unsigned         onset_rise_cnt = 0;
    int unsigned         onset_nz_cnt = 0;
    logic [BINS_W-1:0]   onset_bins = pof_pkg::BINS_RESET;
    logic [THR_W-1:0]    onset_rise_thr = pof_pkg::RISE_RESET;
    logic [ZT_W-1:0]     onset_zero_thr = pof_pkg::ZERO_RESET;
    frame_result_t       frame_results_due[$];
    int unsigned         mismatches = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned frame_length(input logic [BINS_W-1:0] b);
        if (b == 0)
            return 1;
        if (b > STORE_BINS)
            return STORE_BINS;
        return 32'(b);
    endfunction

    function automatic int unsigned bins_left();
        int unsigned total;
        total = frame_length(stim_bins);
        return (stim_pos >= total) ? 1 : total - stim_pos;
    endfunction

    // Mix of zero, threshold-edge, full-scale, random and near-ratio magnitudes.
    function automatic logic [MAG_IN_W-1:0] mag_pick(input logic [MAG_IN_W-1:0] old);
        longint b;
        int     d;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return stim_zero;
            2: return (stim_zero == MAG_MAX) ? MAG_MAX : stim_zero + 1'b1;
            3: return MAG_MAX;
            4, 5: return MAG_IN_W'($urandom);
            default:
            begin
                if (old > stim_zero)
                    b = (longint'({48'd0, stim_rise}) * longint'({40'd0, old}) + 16383)
                        >>> 14;
                else
                    b = longint'({40'd0, stim_zero});
                d = int'($urandom_range(0, 2)) - 1;
                b = b + d;
                if (b < 0)
                    b = 0;
                if (b > longint'({40'd0, MAG_MAX}))
                    b = longint'({40'd0, MAG_MAX});
                return b[MAG_IN_W-1:0];
            end
        endcase
    endfunction

    task automatic queue_bin(input logic [MAG_IN_W-1:0] m);
        bins_to_send.push_back(m);
        stim_prev[stim_pos] = m;
        if (stim_pos + 1 >= frame_length(stim_bins))
            stim_pos = 0;
        else
            stim_pos = stim_pos + 1;
        sent_count = sent_count + 1;
    endtask

    task automatic queue_random_bins(input int unsigned n);
        repeat (n) queue_bin(mag_pick(stim_prev[stim_pos]));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            pof_pkg::REG_BINS_IN_USE:    stim_bins = val[BINS_W-1:0];
            pof_pkg::REG_RISE_THRESHOLD: stim_rise = val[THR_W-1:0];
            pof_pkg::REG_ZERO_THRESHOLD: stim_zero = val[ZT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Block is idle once every queued bin was accepted, all results are out,
    // and the pipe has drained.
    task automatic drain_and_rest();
        while (accepted_count != sent_count || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic onset_step(input logic [MAG_IN_W-1:0] now);
        logic [MAG_IN_W-1:0] old;
        logic                rising;
        int unsigned         slot;
        int unsigned         total;
        longint unsigned     q;
        frame_result_t       r;
        slot  = onset_pos;
        total = frame_length(onset_bins);
        old   = onset_prev[slot];
        if (old > onset_zero_thr)
            rising = ({40'd0, now} << RISE_SHIFT) >= ({48'd0, onset_rise_thr} * {40'd0, old});
        else
            rising = now > onset_zero_thr;
        if (rising)
            onset_rise_cnt = onset_rise_cnt + 1;
        if (now > onset_zero_thr)
            onset_nz_cnt = onset_nz_cnt + 1;
        onset_prev[slot] = now;
        if (slot + 1 >= total)
        begin
            q = 0;
            if (onset_nz_cnt != 0)
            begin
                q = (longint'(onset_rise_cnt) << FRAC_BITS) / onset_nz_cnt;
                if (q > longint'(pof_pkg::FRAC_ONE))
                    q = longint'(pof_pkg::FRAC_ONE);
            end
            r.fraction = q[FRAC_W-1:0];
            r.rising   = onset_rise_cnt[CNT_OUT_W-1:0];
            r.nonzero  = onset_nz_cnt[CNT_OUT_W-1:0];
            frame_results_due.push_back(r);
            onset_pos      = 0;
            onset_rise_cnt = 0;
            onset_nz_cnt   = 0;
        end
        else
            onset_pos = slot + 1;
    endtask

    // input driver
    always @(posedge clk)
    begin
        logic                nv;
        logic [MAG_IN_W-1:0] nm;
        nv = in_valid;
        nm = magnitude;
        if (!rst_n)
            nv = 1'b0;
        else if (!in_valid || in_ready)
        begin
            nv = 1'b0;
            if (in_gap > 0)
                in_gap = in_gap - 1;
            else if (!calm && $urandom_range(0, 11) == 0)
                in_gap = $urandom_range(1, 18) - 1;
            else if (bins_to_send.size() != 0)
            begin
                nv = 1'b1;
                nm = bins_to_send.pop_front();
            end
        end
        in_valid  <= nv;
        magnitude <= nm;
    end

    // output back-pressure
    always @(posedge clk)
    begin
        logic nr;
        nr = 1'b1;
        if (!rst_n)
            nr = 1'b0;
        else if (out_stall > 0)
        begin
            out_stall = out_stall - 1;
            nr = 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_stall = $urandom_range(1, 18) - 1;
            nr = 1'b0;
        end
        out_ready <= nr;
    end

    // monitor: track register writes, predict on accepted bins, check results
    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pof_pkg::REG_BINS_IN_USE:    onset_bins     = cfg_data[BINS_W-1:0];
                    pof_pkg::REG_RISE_THRESHOLD: onset_rise_thr = cfg_data[THR_W-1:0];
                    pof_pkg::REG_ZERO_THRESHOLD: onset_zero_thr = cfg_data[ZT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                onset_step(magnitude);
                accepted_count = accepted_count + 1;
            end
            if (out_valid && out_ready)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("unexpected result transaction: rise_fraction %0d",
                           rise_fraction, " rising_bins %0d nonzero_bins %0d",
                           rising_bins, nonzero_bins);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    e = frame_results_due.pop_front();
                    if (rise_fraction !== e.fraction)
                    begin
                        $error("rise_fraction: expected %0d, actual %0d", e.fraction, rise_fraction);
                        mismatches = mismatches + 1;
                    end
                    if (rising_bins !== e.rising)
                    begin
                        $error("rising_bins: expected %0d, actual %0d", e.rising, rising_bins);
                        mismatches = mismatches + 1;
                    end
                    if (nonzero_bins !== e.nonzero)
                    begin
                        $error("nonzero_bins: expected %0d, actual %0d", e.nonzero, nonzero_bins);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned stop_at;
        int unsigned calm_at;
        int unsigned k;
        bit [2:0]    reg_mask;
        logic [CFG_W-1:0] v;

        for (int i = 0; i < STORE_BINS; i++)
        begin
            stim_prev[i]  = '0;
            onset_prev[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // part of a frame under the reset register values, closed by a size cut
        queue_random_bins(16);
        drain_and_rest();
        set_reg(pof_pkg::REG_BINS_IN_USE, CFG_W'(1));
        queue_random_bins(1);
        drain_and_rest();

        // short frames: default thresholds, then threshold edges and ratio 1.0
        set_reg(pof_pkg::REG_BINS_IN_USE, CFG_W'(4));
        queue_bin(24'd0);
        queue_bin(24'd100);
        queue_bin(24'd101);
        queue_bin(MAG_MAX);
        drain_and_rest();
        set_reg(pof_pkg::REG_ZERO_THRESHOLD, CFG_W'(100));
        set_reg(pof_pkg::REG_RISE_THRESHOLD, CFG_W'(16384));
        queue_bin(24'd101);
        queue_bin(24'd101);
        queue_bin(24'd100);
        queue_bin(MAG_MAX);
        drain_and_rest();

        // zero ratio: more rising than nonzero bins, fraction saturates
        set_reg(pof_pkg::REG_RISE_THRESHOLD, '0);
        set_reg(pof_pkg::REG_ZERO_THRESHOLD, '0);
        queue_bin(24'd0);
        queue_bin(24'd0);
        queue_bin(24'd0);
        queue_bin(24'd5);
        drain_and_rest();

        // largest ratio
        set_reg(pof_pkg::REG_RISE_THRESHOLD, CFG_W'(16'hFFFF));
        queue_bin(MAG_MAX);
        queue_bin(24'd1);
        queue_bin(24'd0);
        queue_bin(MAG_MAX);
        drain_and_rest();

        // zero threshold at full scale: nothing counts
        set_reg(pof_pkg::REG_ZERO_THRESHOLD, MAG_MAX);
        queue_random_bins(4);
        drain_and_rest();

        // zero bins per frame behaves as one; unused index is ignored
        set_reg(pof_pkg::REG_BINS_IN_USE, '0);
        set_reg(REG_UNUSED, CFG_W'($urandom));
        set_reg(pof_pkg::REG_ZERO_THRESHOLD, '0);
        queue_random_bins(2);
        drain_and_rest();

        // frame size cut below the current position mid-frame
        set_reg(pof_pkg::REG_BINS_IN_USE, CFG_W'(12));
        queue_random_bins(4);
        drain_and_rest();
        set_reg(pof_pkg::REG_BINS_IN_USE, CFG_W'(2));
        queue_random_bins(1);
        drain_and_rest();

        // oversized register saturates to a full store frame, all bins rising
        set_reg(pof_pkg::REG_BINS_IN_USE, CFG_W'(12'hFFF));
        set_reg(pof_pkg::REG_RISE_THRESHOLD, '0);
        repeat (bins_left()) queue_bin(MAG_IN_W'($urandom_range(1, MAG_MAX)));
        drain_and_rest();

        stop_at = sent_count + RANDOM_ITEMS;
        calm_at = sent_count + RANDOM_ITEMS * 17 / 20;
        while (sent_count < stop_at)
        begin
            drain_and_rest();
            if (sent_count >= calm_at)
                calm = 1'b1;
            reg_mask = 3'($urandom_range(1, 7));
            if (reg_mask[0])
            begin
                case ($urandom_range(0, 19))
                    0:       v = '0;
                    1, 2, 3: v = CFG_W'($urandom_range(1, 3));
                    4:       v = CFG_W'($urandom_range(41, 200));
                    default: v = CFG_W'($urandom_range(4, 40));
                endcase
                set_reg(pof_pkg::REG_BINS_IN_USE, v);
            end
            if (reg_mask[1])
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = CFG_W'(16'hFFFF);
                    2:       v = CFG_W'(16384);
                    3:       v = CFG_W'(pof_pkg::RISE_RESET);
                    default: v = CFG_W'($urandom_range(0, 16'hFFFF));
                endcase
                set_reg(pof_pkg::REG_RISE_THRESHOLD, v);
            end
            if (reg_mask[2])
            begin
                case ($urandom_range(0, 7))
                    0, 1:    v = '0;
                    2, 3:    v = CFG_W'($urandom_range(0, 255));
                    4:       v = CFG_W'($urandom_range(0, 16'hFFFF));
                    5:       v = MAG_MAX;
                    default: v = CFG_W'($urandom_range(0, MAG_MAX));
                endcase
                set_reg(pof_pkg::REG_ZERO_THRESHOLD, v);
            end
            if ($urandom_range(0, 15) == 0)
                set_reg(REG_UNUSED, CFG_W'($urandom));
            k = $urandom_range(1, 4);
            repeat (k) queue_random_bins(bins_left());
            // sometimes stop inside a frame so the next setting lands mid-frame
            if ($urandom_range(0, 3) == 0)
                queue_random_bins($urandom_range(1, bins_left()));
        end

        while (accepted_count != sent_count)
            @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### percussive_onset_fraction_top.f
design/pof_pkg.sv
design/pof_ram.sv
design/pof_queue.sv
design/pof_front.sv
design/pof_back.sv
design/percussive_onset_fraction_top.sv
tb/percussive_onset_fraction_top_test.sv
